### rtl/next_fit_bitmap_id_allocator_unit_assert.svh
`ifndef NEXT_FIT_BITMAP_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define NEXT_FIT_BITMAP_ID_ALLOCATOR_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define NFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define NFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/nfba_pkg.sv
package nfba_pkg;

  // Operation codes of an input beat
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  // The scan looks at one chunk of the bitmap per cycle
  localparam int CHUNK_BITS = 8;
  localparam int CHUNK_SH   = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_FREE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit_alloc;
    logic commit_free;
  } dp_cmd_t;

  typedef struct packed {
    logic last_chunk;
  } dp_stat_t;

endpackage

### rtl/nfba_ctrl.sv
module nfba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_operation,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output nfba_pkg::dp_cmd_t  cmd,
  input  nfba_pkg::dp_stat_t stat
);
  import nfba_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register may be reloaded once its beat leaves
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == OP_FREE) ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.last_chunk) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC, S_FREE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    cmd.load         = (state_r == S_IDLE) && in_valid;
    cmd.step         = (state_r == S_SCAN);
    cmd.commit_alloc = (state_r == S_ALLOC) && out_free;
    cmd.commit_free  = (state_r == S_FREE) && out_free;
  end

  always_comb begin
    priority if (cmd.commit_alloc || cmd.commit_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/nfba_datapath.sv
module nfba_datapath #(
  parameter int NUM_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nfba_pkg::dp_cmd_t  cmd,
  output nfba_pkg::dp_stat_t stat,
  input  logic [7:0]         in_slot_to_free,
  output logic [1:0]         out_status,
  output logic [7:0]         out_granted_slot
);
  import nfba_pkg::*;

  localparam int SW     = $clog2(NUM_SLOTS);
  localparam int NCHUNK = (NUM_SLOTS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CW     = $clog2(NCHUNK);
  localparam int IW     = CW + CHUNK_SH;
  localparam int PADW   = NCHUNK * CHUNK_BITS;

  logic [NUM_SLOTS-1:0]  used_r, used_nxt;
  logic [SW-1:0]         ptr_r, ptr_nxt;
  logic [7:0]            slot_r;
  logic [CW-1:0]         chunk_r;
  logic                  hit_hi_r, hit_any_r;
  logic [SW-1:0]         hi_slot_r, any_slot_r;
  logic [1:0]            status_r, status_nxt;
  logic [7:0]            granted_r, granted_nxt;

  logic [PADW-1:0]       free_pad;
  logic [CHUNK_BITS-1:0] chunk_bits;
  logic                  hi_f, any_f;
  logic [IW-1:0]         hi_idx, any_idx;
  logic [SW-1:0]         pick;
  logic [SW-1:0]         free_idx;
  logic                  free_ok;

  assign stat.last_chunk = (chunk_r == CW'(NCHUNK - 1));
  assign out_status       = status_r;
  assign out_granted_slot = granted_r;

  // Slots past the end read as used so the scan never picks them
  always_comb begin
    free_pad                = '0;
    free_pad[NUM_SLOTS-1:0] = ~used_r;
  end

  assign chunk_bits = free_pad[{chunk_r, {CHUNK_SH{1'b0}}} +: CHUNK_BITS];

  // Lowest free slot in the chunk, overall and at or above the pointer
  always_comb begin
    logic [IW-1:0] idx;
    hi_f    = 1'b0;
    any_f   = 1'b0;
    hi_idx  = '0;
    any_idx = '0;
    for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
      idx = {chunk_r, CHUNK_SH'(j)};
      if (chunk_bits[j]) begin
        any_f   = 1'b1;
        any_idx = idx;
        if (idx >= IW'(ptr_r)) begin
          hi_f   = 1'b1;
          hi_idx = idx;
        end
      end
    end
  end

  assign pick     = hit_hi_r ? hi_slot_r : any_slot_r;
  assign free_idx = slot_r[SW-1:0];
  assign free_ok  = ({1'b0, slot_r} < 9'(NUM_SLOTS)) && used_r[free_idx];

  always_comb begin
    used_nxt    = used_r;
    ptr_nxt     = ptr_r;
    status_nxt  = status_r;
    granted_nxt = granted_r;
    priority if (cmd.commit_alloc) begin
      if (hit_hi_r || hit_any_r) begin
        used_nxt[pick] = 1'b1;
        ptr_nxt        = (pick >= SW'(NUM_SLOTS - 1)) ? '0 : pick + 1'b1;
        status_nxt     = ST_OK;
        granted_nxt    = 8'(pick);
      end else begin
        status_nxt  = ST_FULL;
        granted_nxt = '0;
      end
    end else if (cmd.commit_free) begin
      granted_nxt = '0;
      if (free_ok) begin
        used_nxt[free_idx] = 1'b0;
        status_nxt         = ST_OK;
        if (free_idx < ptr_r) begin
          ptr_nxt = free_idx;
        end
      end else begin
        status_nxt = ST_BAD_FREE;
      end
    end else begin
      used_nxt = used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ptr_r  <= '0;
    end else begin
      used_r <= used_nxt;
      ptr_r  <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r   <= '0;
      hit_hi_r  <= 1'b0;
      hit_any_r <= 1'b0;
    end else if (cmd.load) begin
      chunk_r   <= '0;
      hit_hi_r  <= 1'b0;
      hit_any_r <= 1'b0;
    end else if (cmd.step) begin
      chunk_r <= chunk_r + 1'b1;
      if (!hit_hi_r && hi_f) begin
        hit_hi_r <= 1'b1;
      end
      if (!hit_any_r && any_f) begin
        hit_any_r <= 1'b1;
      end
    end
  end

  // Payload registers: hold the beat and the first hits of the scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r <= in_slot_to_free;
    end
    if (cmd.step && !hit_hi_r && hi_f) begin
      hi_slot_r <= hi_idx[SW-1:0];
    end
    if (cmd.step && !hit_any_r && any_f) begin
      any_slot_r <= any_idx[SW-1:0];
    end
    if (cmd.commit_alloc || cmd.commit_free) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
    end
  end

endmodule

### rtl/next_fit_bitmap_id_allocator_unit.sv
// Channel  Ports                                         Direction
// in       in_valid in_ready in_operation in_slot_to_free  request beat in
// out      out_valid out_ready out_status out_granted_slot result beat out
//
// One item at a time. A free is accepted and then committed from S_FREE;
// an allocate first scans the bitmap in S_SCAN, one 8-slot chunk of the
// bitmap per cycle, and then commits from S_ALLOC.
// Reset clears the bitmap and the next-fit pointer at once; no sweep.
// A result waiting on out_ready does not block the next accept; only the
// commit of that next item waits for the result register to empty.
module next_fit_bitmap_id_allocator_unit #(
  parameter int NUM_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_slot_to_free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_granted_slot
);
  import nfba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nfba_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .stat         (stat)
  );

  nfba_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_slot_to_free  (in_slot_to_free),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot)
  );

endmodule

### rtl/nfba_checker.sv
`include "next_fit_bitmap_id_allocator_unit_assert.svh"

module nfba_checker #(
  parameter int NUM_SLOTS = 32
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_operation,
  input logic [7:0] in_slot_to_free,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_granted_slot
);
  import nfba_pkg::*;

  logic in_beat;
  logic in_stall;
  logic out_stall;
  logic status_known;
  logic granted_ok;

  assign in_beat      = in_valid && in_ready;
  assign in_stall     = in_valid && !in_ready;
  assign out_stall    = out_valid && !out_ready;
  assign status_known = (out_status == ST_OK) || (out_status == ST_FULL)
                        || (out_status == ST_BAD_FREE);
  assign granted_ok   = (out_granted_slot == 8'd0)
                        || ((out_status == ST_OK) && ({1'b0, out_granted_slot} < 9'(NUM_SLOTS)));

  // A waiting request holds its payload
  `NFBA_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable({in_operation, in_slot_to_free}), "request changed")

  // A stalled result holds its payload
  `NFBA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({out_status, out_granted_slot}), "result changed")

  // An accepted beat keeps the block busy on the next cycle
  `NFBA_ASSERT_NEXT(a_busy_after_accept, in_beat, !in_ready, "input ready right after accept")

  // Only defined status codes, and a slot number only with an ok status
  `NFBA_ASSERT(a_status_code, !out_valid || status_known, "undefined status code")
  `NFBA_ASSERT(a_granted_range, !out_valid || granted_ok, "granted slot out of range")

endmodule

bind next_fit_bitmap_id_allocator_unit nfba_checker #(
  .NUM_SLOTS (NUM_SLOTS)
) u_nfba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_operation     (in_operation),
  .in_slot_to_free  (in_slot_to_free),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_granted_slot (out_granted_slot)
);

### sim/next_fit_bitmap_id_allocator_unit_checker.sv
`timescale 1ns / 1ps

module next_fit_bitmap_id_allocator_unit_checker #(
  parameter int NUM_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_slot_to_free,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_status,
  input  logic [7:0] out_granted_slot,
  output int         error_count,
  output int         pending_count,
  output int         request_count,
  output int         grant_count,
  output int         full_count,
  output int         reject_count
);
  import nfba_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot;
  } slot_reply_t;

  logic [NUM_SLOTS-1:0] slot_taken;
  int unsigned          scan_from;
  slot_reply_t          reply_queue[$];
  slot_reply_t          want;

  function automatic int unsigned slot_after(int unsigned s);
    return (s >= NUM_SLOTS - 1) ? 0 : s + 1;
  endfunction

  // Apply one request to the shadow bitmap and return the reply it must produce.
  function automatic slot_reply_t apply_request(logic op, logic [7:0] slot);
    slot_reply_t r;
    int unsigned p;
    r.status = ST_OK;
    r.slot   = '0;
    if (op == OP_ALLOC) begin
      p = (scan_from >= NUM_SLOTS) ? 0 : scan_from;
      r.status = ST_FULL;
      for (int n = 0; n < NUM_SLOTS; n++) begin
        if (!slot_taken[p]) begin
          slot_taken[p] = 1'b1;
          r.status      = ST_OK;
          r.slot        = p[7:0];
          scan_from     = slot_after(p);
          break;
        end
        p = slot_after(p);
      end
    end else if (slot >= NUM_SLOTS || !slot_taken[slot]) begin
      r.status = ST_BAD_FREE;
    end else begin
      slot_taken[slot] = 1'b0;
      if (slot < scan_from) scan_from = slot;
    end
    return r;
  endfunction

  initial begin
    error_count   = 0;
    pending_count = 0;
    request_count = 0;
    grant_count   = 0;
    full_count    = 0;
    reject_count  = 0;
    slot_taken    = '0;
    scan_from     = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      slot_taken = '0;
      scan_from  = 0;
      reply_queue.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = apply_request(in_operation, in_slot_to_free);
        reply_queue.push_back(want);
        request_count++;
        if (want.status == ST_OK && in_operation == OP_ALLOC) grant_count++;
        if (want.status == ST_FULL) full_count++;
        if (want.status == ST_BAD_FREE) reject_count++;
      end
      if (out_valid && out_ready) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: status=%0d slot=%0d",
                   $time, out_status, out_granted_slot);
          error_count++;
        end else begin
          want = reply_queue.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, out_status);
            error_count++;
          end
          if (out_granted_slot !== want.slot) begin
            $display("%0t: granted_slot mismatch: expected %0d actual %0d",
                     $time, want.slot, out_granted_slot);
            error_count++;
          end
        end
      end
    end
    pending_count = reply_queue.size();
  end

endmodule

### sim/next_fit_bitmap_id_allocator_unit_test.sv
`timescale 1ns / 1ps

module next_fit_bitmap_id_allocator_unit_test;
  import nfba_pkg::*;

  localparam int NUM_SLOTS   = 32;
  localparam int PHASE_ITEMS = 600;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic       in_operation    = OP_ALLOC;
  logic [7:0] in_slot_to_free = 8'd0;
  logic       out_ready       = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] out_status;
  logic [7:0] out_granted_slot;

  int error_count, pending_count;
  int request_count, grant_count, full_count, reject_count;
  int gap_pct   = 29;
  int stall_pct = 76;
  int cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  next_fit_bitmap_id_allocator_unit #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot_to_free  (in_slot_to_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot)
  );

  next_fit_bitmap_id_allocator_unit_checker #(.NUM_SLOTS(NUM_SLOTS)) slot_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot_to_free  (in_slot_to_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot),
    .error_count      (error_count),
    .pending_count    (pending_count),
    .request_count    (request_count),
    .grant_count      (grant_count),
    .full_count       (full_count),
    .reject_count     (reject_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_count);
      $display("next_fit_bitmap_id_allocator_unit_test failed");
      $finish;
    end
  end

  // Present one request beat and hold it until accepted.
  task automatic send_request(input logic op, input logic [7:0] slot);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_slot_to_free <= slot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Alternate fill-heavy and drain-heavy stretches so the bitmap swings
  // between empty and full; most frees name a slot in range.
  task automatic random_requests(input int count);
    int alloc_pct;
    logic [7:0] slot;
    for (int i = 0; i < count; i++) begin
      alloc_pct = ((i / 100) % 2 == 0) ? 75 : 30;
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_request(OP_ALLOC, 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 99) < 85) slot = 8'($urandom_range(0, NUM_SLOTS - 1));
        else slot = 8'($urandom_range(NUM_SLOTS, 255));
        send_request(OP_FREE, slot);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad frees on an empty map, fill to full, then reuse.
    send_request(OP_FREE, 8'd0);
    send_request(OP_FREE, 8'd255);
    send_request(OP_FREE, 8'(NUM_SLOTS));
    for (int i = 0; i < NUM_SLOTS; i++) send_request(OP_ALLOC, 8'(i * 37));
    send_request(OP_ALLOC, 8'd0);
    send_request(OP_FREE, 8'd7);
    send_request(OP_FREE, 8'd7);
    send_request(OP_FREE, 8'(NUM_SLOTS - 1));
    send_request(OP_ALLOC, 8'd255);
    send_request(OP_ALLOC, 8'd0);
    send_request(OP_ALLOC, 8'd0);

    random_requests(PHASE_ITEMS);
    gap_pct   = 76;
    stall_pct = 29;
    random_requests(PHASE_ITEMS);
    gap_pct   = 0;
    stall_pct = 0;
    random_requests(PHASE_ITEMS);
    in_valid <= 1'b0;

    // Let the last accepted beat reach the checker before draining.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d requests across three handshake mixes: %0d grants,", request_count,
             grant_count);
    $display("%0d full reports and %0d rejected frees", full_count, reject_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("next_fit_bitmap_id_allocator_unit_test passed");
    end else begin
      $display("next_fit_bitmap_id_allocator_unit_test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/nfba_pkg.sv
rtl/nfba_ctrl.sv
rtl/nfba_datapath.sv
rtl/next_fit_bitmap_id_allocator_unit.sv
rtl/nfba_checker.sv
sim/next_fit_bitmap_id_allocator_unit_checker.sv
sim/next_fit_bitmap_id_allocator_unit_test.sv
